@@ hdl/min_square_window_range_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the square window range block
// Immediate-style wrappers around concurrent checks on clk with rst_n.
// ----------------------------------------------------------------------------
`ifndef MIN_SQUARE_WINDOW_RANGE_ASSERT_SVH
`define MIN_SQUARE_WINDOW_RANGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSWR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mswr_pkg.sv @@
// ----------------------------------------------------------------------------
// mswr_pkg
// Shared widths, register indexes and defaults of the window range block.
// ----------------------------------------------------------------------------
package mswr_pkg;

  localparam int PIXEL_W    = 32;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int SIDE_W     = 8;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 128;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IDX_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_IDX_WINDOW_SIDE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [SIDE_W-1:0]     RST_WINDOW_SIDE  = 8'd2;

endpackage

@@ hdl/mswr_pix_if.sv @@
// ----------------------------------------------------------------------------
// mswr_pix_if
// Pixel input channel: one pixel per beat.
// ----------------------------------------------------------------------------
interface mswr_pix_if import mswr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

@@ hdl/mswr_res_if.sv @@
// ----------------------------------------------------------------------------
// mswr_res_if
// Result channel: one frame result per beat.
// ----------------------------------------------------------------------------
interface mswr_res_if import mswr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] min_range;
  logic               no_window;

  modport source (output valid, output min_range, output no_window, input ready);
  modport sink (input valid, input min_range, input no_window, output ready);
endinterface

@@ hdl/mswr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mswr_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface mswr_cfg_if import mswr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/min_square_window_range.sv @@
// ----------------------------------------------------------------------------
// min_square_window_range
// Smallest max-minus-min over all square windows of a raster-order frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  in_pix    in         pixel, raster order
//  out_res   out        min_range, no_window, one beat per frame
//  cfg_wr    in         index, data (frame_width, frame_height, window_side)
//
//  A pixel of a frame where the window cannot fit only advances the counters.
//  Any other pixel is pushed into the row deques and, once the row window is
//  full, the row fronts go into a column deque; each step waits until both the
//  max and min deques are idle; each deque drops dominated tail entries via a
//  registered memory read. After reset, after every register write and after
//  every frame a clearing pass empties all MAX_WIDTH column pointer entries;
//  no pixel is taken meanwhile. Pixels are still taken while a result waits on out_res.
// ----------------------------------------------------------------------------
`include "min_square_window_range_assert.svh"

module min_square_window_range import mswr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic      clk,
  input  logic      rst_n,
  mswr_pix_if.sink  in_pix,
  mswr_res_if.source out_res,
  mswr_cfg_if.sink  cfg_wr
);

  localparam int IW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int PW   = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int SW   = $clog2(MAX_WIDTH + 1);
  localparam int CLW  = $clog2(MAX_WIDTH);
  localparam int RLW  = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int PTRW = 2 * (IW + CW);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_ROW  = 2'd1;
  localparam logic [1:0] T_COL  = 2'd2;
  localparam logic [1:0] T_FIN  = 2'd3;

  logic [CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [SIDE_W-1:0]     window_side_r;

  logic [1:0]         st_r, st_nxt;
  logic [CLW-1:0]     col_r, col_nxt;
  logic [RLW-1:0]     row_r, row_nxt;
  logic [PIXEL_W-1:0] best_r, best_nxt;
  logic               seen_r, seen_nxt;
  logic               out_valid_r;
  logic [PIXEL_W-1:0] min_range_r;
  logic               no_window_r;
  logic               clr_busy_r;
  logic [CLW-1:0]     clr_idx_r;

  logic [IW-1:0] rhead_max_r, rhead_min_r;
  logic [CW-1:0] rcnt_max_r, rcnt_min_r;

  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [SIDE_W-1:0] k_eff;
  logic              fits, col_full, row_full, col_last, row_last;
  logic [CLW-1:0]    wc;
  logic              accept, cfg_acc, units_idle, adv, out_load, ptr_wr_col;
  logic [PIXEL_W-1:0] diff;

  logic [PTRW-1:0] ptr_mem [MAX_WIDTH];
  logic [PTRW-1:0] ptr_rdata_r;
  logic [IW-1:0]   p_hmax, p_hmin;
  logic [CW-1:0]   p_cmax, p_cmin;

  logic               u_start;
  logic [SW-1:0]      u_slot;
  logic [IW-1:0]      u_head_max, u_head_min, o_head_max, o_head_min;
  logic [CW-1:0]      u_cnt_max, u_cnt_min, o_cnt_max, o_cnt_min;
  logic [PIXEL_W-1:0] u_val_max, u_val_min, front_max, front_min;
  logic [PW-1:0]      u_at;
  logic               busy_max, busy_min;

  // Effective sizes: zero acts as one; oversize frame sizes are clamped, an oversize window side clears fits.
  assign w_eff = (frame_width_r == '0) ? WW'(1) :
                 (32'(frame_width_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width_r);
  assign h_eff = (frame_height_r == '0) ? HW'(1) :
                 (32'(frame_height_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) :
                 HW'(frame_height_r);
  assign k_eff = (window_side_r == '0) ? SIDE_W'(1) : window_side_r;
  assign fits  = (32'(k_eff) <= 32'(MAX_WINDOW)) && (32'(k_eff) <= 32'(w_eff)) &&
                 (32'(k_eff) <= 32'(h_eff));

  assign col_full = (32'(col_r) + 32'd1) >= 32'(k_eff);
  assign row_full = (32'(row_r) + 32'd1) >= 32'(k_eff);
  assign col_last = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign row_last = (32'(row_r) + 32'd1) >= 32'(h_eff);
  assign wc       = CLW'(32'(col_r) + 32'd1 - 32'(k_eff));

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;
  assign in_pix.ready = (st_r == T_IDLE) && !clr_busy_r;
  assign accept       = in_pix.valid && in_pix.ready;
  assign units_idle   = !busy_max && !busy_min;
  assign ptr_wr_col   = (st_r == T_COL) && units_idle;
  assign diff         = front_max - front_min;

  assign {p_hmax, p_cmax, p_hmin, p_cmin} = ptr_rdata_r;

  // The row deques live in the extra slot above the column slots.
  always_comb begin
    if (st_r == T_IDLE) begin
      u_start    = accept && fits;
      u_slot     = SW'(MAX_WIDTH);
      u_head_max = (col_r == '0) ? '0 : rhead_max_r;
      u_cnt_max  = (col_r == '0) ? '0 : rcnt_max_r;
      u_head_min = (col_r == '0) ? '0 : rhead_min_r;
      u_cnt_min  = (col_r == '0) ? '0 : rcnt_min_r;
      u_val_max  = in_pix.pixel;
      u_val_min  = in_pix.pixel;
      u_at       = PW'(col_r);
    end else begin
      u_start    = (st_r == T_ROW) && units_idle && col_full;
      u_slot     = SW'(wc);
      u_head_max = p_hmax;
      u_cnt_max  = p_cmax;
      u_head_min = p_hmin;
      u_cnt_min  = p_cmin;
      u_val_max  = front_max;
      u_val_min  = front_min;
      u_at       = PW'(row_r);
    end
  end

  mswr_deque #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW),
    .KEEP_MAX  (1'b1)
  ) u_dq_max (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (u_start),
    .slot_i (u_slot),
    .head_i (u_head_max),
    .cnt_i  (u_cnt_max),
    .val_i  (u_val_max),
    .at_i   (u_at),
    .side_i (CW'(k_eff)),
    .busy_o (busy_max),
    .head_o (o_head_max),
    .cnt_o  (o_cnt_max),
    .front_o(front_max)
  );

  mswr_deque #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW),
    .KEEP_MAX  (1'b0)
  ) u_dq_min (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (u_start),
    .slot_i (u_slot),
    .head_i (u_head_min),
    .cnt_i  (u_cnt_min),
    .val_i  (u_val_min),
    .at_i   (u_at),
    .side_i (CW'(k_eff)),
    .busy_o (busy_min),
    .head_o (o_head_min),
    .cnt_o  (o_cnt_min),
    .front_o(front_min)
  );

  always_comb begin
    st_nxt   = st_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    best_nxt = best_r;
    seen_nxt = seen_r;
    adv      = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          if (fits) begin
            st_nxt = T_ROW;
          end else begin
            adv = 1'b1;
          end
        end
      end
      T_ROW: begin
        if (units_idle) begin
          if (col_full) begin
            st_nxt = T_COL;
          end else begin
            adv = 1'b1;
          end
        end
      end
      T_COL: begin
        if (units_idle) begin
          if (row_full) begin
            if (diff < best_r) begin
              best_nxt = diff;
            end
            seen_nxt = 1'b1;
          end
          adv = 1'b1;
        end
      end
      T_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_load = 1'b1;
          best_nxt = '1;
          seen_nxt = 1'b0;
          st_nxt   = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
    if (adv) begin
      if (!col_last) begin
        col_nxt = col_r + 1'b1;
        st_nxt  = T_IDLE;
      end else begin
        col_nxt = '0;
        if (!row_last) begin
          row_nxt = row_r + 1'b1;
          st_nxt  = T_IDLE;
        end else begin
          row_nxt = '0;
          st_nxt  = T_FIN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      window_side_r  <= RST_WINDOW_SIDE;
      st_r           <= T_IDLE;
      col_r          <= '0;
      row_r          <= '0;
      best_r         <= '1;
      seen_r         <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_wr.index)
        CFG_IDX_FRAME_WIDTH:  frame_width_r  <= cfg_wr.data;
        CFG_IDX_FRAME_HEIGHT: frame_height_r <= cfg_wr.data;
        CFG_IDX_WINDOW_SIDE:  window_side_r  <= cfg_wr.data[SIDE_W-1:0];
        default: ;
      endcase
      // Any write abandons the frame in progress.
      st_r   <= T_IDLE;
      col_r  <= '0;
      row_r  <= '0;
      best_r <= '1;
      seen_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      best_r <= best_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhead_max_r <= '0;
      rcnt_max_r  <= '0;
      rhead_min_r <= '0;
      rcnt_min_r  <= '0;
    end else if ((st_r == T_ROW) && units_idle) begin
      rhead_max_r <= o_head_max;
      rcnt_max_r  <= o_cnt_max;
      rhead_min_r <= o_head_min;
      rcnt_min_r  <= o_cnt_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (cfg_acc || out_load) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == CLW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // Column pointer memory: read at pixel accept, written back after the column push.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      ptr_mem[clr_idx_r] <= '0;
    end else if (ptr_wr_col) begin
      ptr_mem[wc] <= {o_head_max, o_cnt_max, o_head_min, o_cnt_min};
    end
    if (accept) begin
      ptr_rdata_r <= ptr_mem[wc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      min_range_r <= seen_r ? best_r : '1;
      no_window_r <= !seen_r;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.min_range = min_range_r;
  assign out_res.no_window = no_window_r;

  `MSWR_ASSERT_IMPLY(a_clear_blocks_pixels, clr_busy_r, !in_pix.ready,
    "pixel taken during pointer clearing pass")
  `MSWR_ASSERT_IMPLY(a_row_deque_bound, st_r == T_COL,
    (rcnt_max_r <= CW'(k_eff)) && (rcnt_min_r <= CW'(k_eff)),
    "row deque holds more entries than the window side")
  `MSWR_ASSERT_NEXT(a_frame_end_result, out_load, out_res.valid && clr_busy_r,
    "frame end did not present a result and start clearing")

endmodule

@@ hdl/mswr_deque.sv @@
// ----------------------------------------------------------------------------
// mswr_deque
// Monotonic deque engine over one synchronous memory of deque slots.
// ----------------------------------------------------------------------------
module mswr_deque import mswr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter bit KEEP_MAX   = 1'b1,
  localparam int IW = $clog2(MAX_WINDOW),
  localparam int CW = $clog2(MAX_WINDOW + 1),
  localparam int PW = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT),
  localparam int SW = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SW-1:0]      slot_i,
  input  logic [IW-1:0]      head_i,
  input  logic [CW-1:0]      cnt_i,
  input  logic [PIXEL_W-1:0] val_i,
  input  logic [PW-1:0]      at_i,
  input  logic [CW-1:0]      side_i,
  output logic               busy_o,
  output logic [IW-1:0]      head_o,
  output logic [CW-1:0]      cnt_o,
  output logic [PIXEL_W-1:0] front_o
);

  localparam int DEPTH = (MAX_WIDTH + 1) * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = PW + PIXEL_W;
  localparam int XW    = PW + CW + 1;

  localparam logic [2:0] D_IDLE  = 3'd0;
  localparam logic [2:0] D_CHKH  = 3'd1;
  localparam logic [2:0] D_CHKT  = 3'd2;
  localparam logic [2:0] D_PUSH  = 3'd3;
  localparam logic [2:0] D_FRONT = 3'd4;

  logic [2:0]         st_r, st_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [PIXEL_W-1:0] front_r, front_nxt;
  logic [PIXEL_W-1:0] val_r;
  logic [PW-1:0]      at_r;
  logic [CW-1:0]      side_r;
  logic [AW-1:0]      base_r;
  logic [AW-1:0]      start_base;

  logic [EW-1:0]      mem [DEPTH];
  logic [EW-1:0]      rdata_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [PW-1:0]      rd_pos;
  logic [PIXEL_W-1:0] rd_val;
  logic               expired, dominated;
  logic [IW-1:0]      exp_head;
  logic [CW-1:0]      exp_cnt;

  function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= (IW+1)'(MAX_WINDOW)) ? s - (IW+1)'(MAX_WINDOW) : s;
    return r[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] tail_idx(input logic [IW-1:0] h, input logic [CW-1:0] c);
    return wrap({1'b0, h} + (IW+1)'(c - 1'b1));
  endfunction

  assign start_base = AW'(slot_i) * AW'(MAX_WINDOW);
  assign rd_pos     = rdata_r[EW-1:PIXEL_W];
  assign rd_val     = rdata_r[PIXEL_W-1:0];
  assign expired    = (XW'(rd_pos) + XW'(side_r)) <= XW'(at_r);
  assign dominated  = KEEP_MAX ? (rd_val <= val_r) : (rd_val >= val_r);
  assign exp_head   = expired ? wrap({1'b0, head_r} + (IW+1)'(1)) : head_r;
  assign exp_cnt    = expired ? cnt_r - 1'b1 : cnt_r;

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    front_nxt = front_r;
    rd_en     = 1'b0;
    rd_addr   = base_r;
    wr_en     = 1'b0;
    wr_addr   = base_r;
    unique case (st_r)
      D_IDLE: begin
        if (start) begin
          head_nxt = head_i;
          cnt_nxt  = cnt_i;
          if (cnt_i == '0) begin
            st_nxt = D_PUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = start_base + AW'(head_i);
            st_nxt  = D_CHKH;
          end
        end
      end
      D_CHKH: begin
        // At most one entry leaves the front per push: positions advance by one.
        head_nxt = exp_head;
        cnt_nxt  = exp_cnt;
        if (exp_cnt == '0) begin
          st_nxt = D_PUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = base_r + AW'(tail_idx(exp_head, exp_cnt));
          st_nxt  = D_CHKT;
        end
      end
      D_CHKT: begin
        if (dominated) begin
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            st_nxt = D_PUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = base_r + AW'(tail_idx(head_r, cnt_r - 1'b1));
          end
        end else begin
          st_nxt = D_PUSH;
        end
      end
      D_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = base_r + AW'(wrap({1'b0, head_r} + (IW+1)'(cnt_r)));
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          front_nxt = val_r;
          st_nxt    = D_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = base_r + AW'(head_r);
          st_nxt  = D_FRONT;
        end
      end
      D_FRONT: begin
        front_nxt = rd_val;
        st_nxt    = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    if (st_r == D_IDLE && start) begin
      val_r  <= val_i;
      at_r   <= at_i;
      side_r <= side_i;
      base_r <= start_base;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {at_r, val_r};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign busy_o  = (st_r != D_IDLE);
  assign head_o  = head_r;
  assign cnt_o   = cnt_r;
  assign front_o = front_r;

endmodule
